[design/ppid_pkg.sv]
`default_nettype none

package ppid_pkg;

    // Fixed widths of the gain registers and of the unclamped diagnostic fields
    localparam int GAIN_BITS = 24;
    localparam int RAW_BITS  = 40;

    // Defaults for the top-level parameters
    localparam int DEF_GAIN_FRAC_BITS = 16;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_OUT_BITS       = 32;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GAIN_PROP   = 3'd0,
        REG_GAIN_INT    = 3'd1,
        REG_GAIN_DERIV  = 3'd2,
        REG_LIMIT_LOW   = 3'd3,
        REG_LIMIT_HIGH  = 3'd4,
        REG_PROP_ON_ERR = 3'd5,
        REG_REVERSE_DIR = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic prop_on_error;
        logic reverse_direction;
    } ctrl_t;

endpackage

`default_nettype wire

[design/ppid_cfg_regs.sv]
`default_nettype none

module ppid_cfg_regs #(
    parameter int OUT_BITS      = ppid_pkg::DEF_OUT_BITS,
    parameter int CFG_DATA_BITS = ppid_pkg::DEF_OUT_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [ppid_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]              cfg_data,
    output logic      [ppid_pkg::GAIN_BITS-1:0]        gain_prop,
    output logic      [ppid_pkg::GAIN_BITS-1:0]        gain_int,
    output logic      [ppid_pkg::GAIN_BITS-1:0]        gain_deriv,
    output logic signed [OUT_BITS-1:0]                 limit_low,
    output logic signed [OUT_BITS-1:0]                 limit_high,
    output ppid_pkg::ctrl_t                            ctrl
);

    localparam logic signed [OUT_BITS-1:0] LIMIT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};

    logic [ppid_pkg::GAIN_BITS-1:0] gain_prop_reg, gain_int_reg, gain_deriv_reg;
    logic signed [OUT_BITS-1:0]     limit_low_reg, limit_high_reg;
    ppid_pkg::ctrl_t                ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg                <= '0;
            gain_int_reg                 <= '0;
            gain_deriv_reg               <= '0;
            limit_low_reg                <= '0;
            limit_high_reg               <= LIMIT_MAX;
            ctrl_reg.prop_on_error       <= 1'b1;
            ctrl_reg.reverse_direction   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppid_pkg::REG_GAIN_PROP:   gain_prop_reg  <= cfg_data[ppid_pkg::GAIN_BITS-1:0];
                ppid_pkg::REG_GAIN_INT:    gain_int_reg   <= cfg_data[ppid_pkg::GAIN_BITS-1:0];
                ppid_pkg::REG_GAIN_DERIV:  gain_deriv_reg <= cfg_data[ppid_pkg::GAIN_BITS-1:0];
                ppid_pkg::REG_LIMIT_LOW:   limit_low_reg  <= cfg_data[OUT_BITS-1:0];
                ppid_pkg::REG_LIMIT_HIGH:  limit_high_reg <= cfg_data[OUT_BITS-1:0];
                ppid_pkg::REG_PROP_ON_ERR: ctrl_reg.prop_on_error     <= cfg_data[0];
                ppid_pkg::REG_REVERSE_DIR: ctrl_reg.reverse_direction <= cfg_data[0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    assign gain_prop  = gain_prop_reg;
    assign gain_int   = gain_int_reg;
    assign gain_deriv = gain_deriv_reg;
    assign limit_low  = limit_low_reg;
    assign limit_high = limit_high_reg;
    assign ctrl       = ctrl_reg;

endmodule

`default_nettype wire

[design/ppid_scale.sv]
`default_nettype none

module ppid_scale #(
    parameter int GAIN_FRAC_BITS = ppid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int X_BITS         = ppid_pkg::DEF_SAMPLE_BITS + 1,
    parameter int PROD_BITS      = ppid_pkg::GAIN_BITS + ppid_pkg::DEF_SAMPLE_BITS + 3
) (
    input  wire logic        [ppid_pkg::GAIN_BITS-1:0] gain,
    input  wire logic signed [X_BITS-1:0]              x,
    input  wire logic                                  negate,
    output logic signed      [PROD_BITS-1:0]           term
);

    localparam int NAT_BITS = ppid_pkg::GAIN_BITS + 1 + X_BITS;
    localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (GAIN_FRAC_BITS - 1);

    logic signed [NAT_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0] prod_sgn;
    logic signed [PROD_BITS-1:0] rounded;

    always_comb begin
        prod     = $signed({1'b0, gain}) * x;
        prod_sgn = negate ? -PROD_BITS'(prod) : PROD_BITS'(prod);
        // round half up, then floor through the arithmetic shift
        rounded  = prod_sgn + HALF;
        term     = rounded >>> GAIN_FRAC_BITS;
    end

endmodule

`default_nettype wire

[design/ppid_core.sv]
`default_nettype none

module ppid_core #(
    parameter int GAIN_FRAC_BITS = ppid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int SAMPLE_BITS    = ppid_pkg::DEF_SAMPLE_BITS,
    parameter int OUT_BITS       = ppid_pkg::DEF_OUT_BITS
) (
    input  wire logic signed [SAMPLE_BITS-1:0]         measurement,
    input  wire logic signed [SAMPLE_BITS-1:0]         setpoint,
    input  wire logic                                  mode,
    input  wire ppid_pkg::ctrl_t                       ctrl,
    input  wire logic        [ppid_pkg::GAIN_BITS-1:0] gain_prop,
    input  wire logic        [ppid_pkg::GAIN_BITS-1:0] gain_int,
    input  wire logic        [ppid_pkg::GAIN_BITS-1:0] gain_deriv,
    input  wire logic signed [OUT_BITS-1:0]            limit_low,
    input  wire logic signed [OUT_BITS-1:0]            limit_high,
    input  wire logic                                  auto_active,
    input  wire logic signed [OUT_BITS-1:0]            integral_sum,
    input  wire logic signed [SAMPLE_BITS-1:0]         prev_meas,
    input  wire logic signed [SAMPLE_BITS-1:0]         latest_meas,
    input  wire logic signed [OUT_BITS-1:0]            latest_out,
    output logic signed      [OUT_BITS-1:0]            integral_sum_next,
    output logic signed      [SAMPLE_BITS-1:0]         prev_meas_next,
    output logic signed      [OUT_BITS-1:0]            latest_out_next,
    output logic signed      [ppid_pkg::RAW_BITS-1:0]  raw_output,
    output logic signed      [ppid_pkg::RAW_BITS-1:0]  raw_integral
);

    localparam int XW  = SAMPLE_BITS + 1;
    localparam int PW  = ppid_pkg::GAIN_BITS + XW + 2;
    localparam int SW0 = ((OUT_BITS > PW) ? OUT_BITS : PW) + 3;
    localparam int SW  = (SW0 > ppid_pkg::RAW_BITS) ? SW0 : ppid_pkg::RAW_BITS;
    localparam int RB  = ppid_pkg::RAW_BITS;
    localparam logic signed [RB-1:0] RAW_MAX = {1'b0, {(RB-1){1'b1}}};
    localparam logic signed [RB-1:0] RAW_MIN = {1'b1, {(RB-1){1'b0}}};

    logic                           bump;
    logic signed [OUT_BITS-1:0]     reload;
    logic signed [OUT_BITS-1:0]     integ_eff;
    logic signed [SAMPLE_BITS-1:0]  prev_eff;
    logic signed [XW-1:0]           err, din, kp_x;
    logic signed [PW-1:0]           kp_term, ki_term, kd_term;
    logic signed [SW-1:0]           acc, outv;
    logic signed [SW-1:0]           lim_lo_w, lim_hi_w;
    logic signed [OUT_BITS-1:0]     integ_new, out_new;
    logic [SW-RB:0]                 acc_top, outv_top;
    logic signed [RB-1:0]           acc_sat, outv_sat;

    // Bumpless transfer: reload state on a manual-to-automatic change
    always_comb begin
        bump = mode && !auto_active;
        priority if (latest_out > limit_high) begin
            reload = limit_high;
        end else if (latest_out < limit_low) begin
            reload = limit_low;
        end else begin
            reload = latest_out;
        end
        integ_eff = bump ? reload : integral_sum;
        prev_eff  = bump ? latest_meas : prev_meas;
        err  = XW'(setpoint) - XW'(measurement);
        din  = XW'(measurement) - XW'(prev_eff);
        kp_x = ctrl.prop_on_error ? err : din;
    end

    ppid_scale #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .X_BITS(XW), .PROD_BITS(PW)) u_scale_p (
        .gain(gain_prop), .x(kp_x), .negate(ctrl.reverse_direction), .term(kp_term)
    );

    ppid_scale #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .X_BITS(XW), .PROD_BITS(PW)) u_scale_i (
        .gain(gain_int), .x(err), .negate(ctrl.reverse_direction), .term(ki_term)
    );

    ppid_scale #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .X_BITS(XW), .PROD_BITS(PW)) u_scale_d (
        .gain(gain_deriv), .x(din), .negate(ctrl.reverse_direction), .term(kd_term)
    );

    always_comb begin
        lim_lo_w = SW'(limit_low);
        lim_hi_w = SW'(limit_high);

        acc = SW'(integ_eff) + SW'(ki_term);
        if (!ctrl.prop_on_error) begin
            acc = acc - SW'(kp_term);
        end
        priority if (acc > lim_hi_w) begin
            integ_new = limit_high;
        end else if (acc < lim_lo_w) begin
            integ_new = limit_low;
        end else begin
            integ_new = acc[OUT_BITS-1:0];
        end

        outv = SW'(integ_new) - SW'(kd_term);
        if (ctrl.prop_on_error) begin
            outv = outv + SW'(kp_term);
        end
        priority if (outv > lim_hi_w) begin
            out_new = limit_high;
        end else if (outv < lim_lo_w) begin
            out_new = limit_low;
        end else begin
            out_new = outv[OUT_BITS-1:0];
        end

        // saturate to the diagnostic width when the upper bits disagree
        acc_top  = acc[SW-1:RB-1];
        outv_top = outv[SW-1:RB-1];
        if ((&acc_top) || !(|acc_top)) begin
            acc_sat = acc[RB-1:0];
        end else begin
            acc_sat = acc[SW-1] ? RAW_MIN : RAW_MAX;
        end
        if ((&outv_top) || !(|outv_top)) begin
            outv_sat = outv[RB-1:0];
        end else begin
            outv_sat = outv[SW-1] ? RAW_MIN : RAW_MAX;
        end
    end

    // Manual beats hold the controller state and zero the diagnostics; the top level records their measurement
    always_comb begin
        integral_sum_next = mode ? integ_new : integral_sum;
        prev_meas_next    = mode ? measurement : prev_meas;
        latest_out_next   = mode ? out_new : latest_out;
        raw_output        = mode ? outv_sat : '0;
        raw_integral      = mode ? acc_sat : '0;
    end

endmodule

`default_nettype wire

[design/positional_pid_controller.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_measurement, s_setpoint, s_mode
// m_        out        m_valid / m_ready    m_control_out, m_computed, m_raw_output,
//                                           m_raw_integral
// cfg_      in         cfg_wr_en            cfg_index, cfg_data (no read-back)
//
// One beat per cycle sustained while m_ready is high; a taken beat moves from the
// input register to the result register on m_. The period is set by the integral
// path: one multiply, then two add-and-clamp steps between those two registers.
// Reset (aresetn low, synchronous) clears the handshake, the controller state and
// the registers to their defaults. An m_ready stall holds the result and lets one
// more input beat wait in the input register before s_ready drops.
module positional_pid_controller #(
    parameter int GAIN_FRAC_BITS = ppid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int SAMPLE_BITS    = ppid_pkg::DEF_SAMPLE_BITS,
    parameter int OUT_BITS       = ppid_pkg::DEF_OUT_BITS,
    parameter int CFG_DATA_BITS  = (OUT_BITS > ppid_pkg::GAIN_BITS) ? OUT_BITS
                                                                    : ppid_pkg::GAIN_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic        [ppid_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic        [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]        s_measurement,
    input  wire logic signed [SAMPLE_BITS-1:0]        s_setpoint,
    input  wire logic                                 s_mode,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [OUT_BITS-1:0]           m_control_out,
    output logic                                      m_computed,
    output logic signed      [ppid_pkg::RAW_BITS-1:0] m_raw_output,
    output logic signed      [ppid_pkg::RAW_BITS-1:0] m_raw_integral
);

    localparam int RB = ppid_pkg::RAW_BITS;

    logic [ppid_pkg::GAIN_BITS-1:0] gain_prop, gain_int, gain_deriv;
    logic signed [OUT_BITS-1:0]     lim_lo, lim_hi;
    ppid_pkg::ctrl_t                ctrl;

    logic                           in_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  in_meas_reg, in_sp_reg;
    logic                           in_mode_reg;

    logic                           m_valid_reg;
    logic signed [OUT_BITS-1:0]     control_out_reg;
    logic                           computed_reg;
    logic signed [RB-1:0]           raw_output_reg, raw_integral_reg;

    logic                           auto_active_reg;
    logic signed [OUT_BITS-1:0]     integral_sum_reg, latest_out_reg;
    logic signed [SAMPLE_BITS-1:0]  prev_meas_reg, latest_meas_reg;

    logic signed [OUT_BITS-1:0]     integral_sum_next, latest_out_next;
    logic signed [SAMPLE_BITS-1:0]  prev_meas_next;
    logic signed [RB-1:0]           raw_output_next, raw_integral_next;

    logic out_free, advance, s_take;

    ppid_cfg_regs #(.OUT_BITS(OUT_BITS), .CFG_DATA_BITS(CFG_DATA_BITS)) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .gain_prop  (gain_prop),
        .gain_int   (gain_int),
        .gain_deriv (gain_deriv),
        .limit_low  (lim_lo),
        .limit_high (lim_hi),
        .ctrl       (ctrl)
    );

    ppid_core #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .OUT_BITS      (OUT_BITS)
    ) u_core (
        .measurement       (in_meas_reg),
        .setpoint          (in_sp_reg),
        .mode              (in_mode_reg),
        .ctrl              (ctrl),
        .gain_prop         (gain_prop),
        .gain_int          (gain_int),
        .gain_deriv        (gain_deriv),
        .limit_low         (lim_lo),
        .limit_high        (lim_hi),
        .auto_active       (auto_active_reg),
        .integral_sum      (integral_sum_reg),
        .prev_meas         (prev_meas_reg),
        .latest_meas       (latest_meas_reg),
        .latest_out        (latest_out_reg),
        .integral_sum_next (integral_sum_next),
        .prev_meas_next    (prev_meas_next),
        .latest_out_next   (latest_out_next),
        .raw_output        (raw_output_next),
        .raw_integral      (raw_integral_next)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            auto_active_reg  <= 1'b0;
            integral_sum_reg <= '0;
            prev_meas_reg    <= '0;
            latest_meas_reg  <= '0;
            latest_out_reg   <= '0;
        end else begin
            in_valid_reg <= s_take || (in_valid_reg && !out_free);
            m_valid_reg  <= advance || (m_valid_reg && !m_ready);
            // advance the controller state once per beat moved to the output
            if (advance) begin
                auto_active_reg  <= in_mode_reg;
                integral_sum_reg <= integral_sum_next;
                prev_meas_reg    <= prev_meas_next;
                latest_meas_reg  <= in_meas_reg;
                latest_out_reg   <= latest_out_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_meas_reg <= s_measurement;
            in_sp_reg   <= s_setpoint;
            in_mode_reg <= s_mode;
        end
        if (advance) begin
            control_out_reg  <= latest_out_next;
            computed_reg     <= in_mode_reg;
            raw_output_reg   <= raw_output_next;
            raw_integral_reg <= raw_integral_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_control_out  = control_out_reg;
    assign m_computed     = computed_reg;
    assign m_raw_output   = raw_output_reg;
    assign m_raw_integral = raw_integral_reg;

    a_manual_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && advance && !in_mode_reg) |=>
            (!m_computed && m_raw_output == '0 && m_raw_integral == '0))
        else $error("manual beat produced nonzero diagnostics");

    a_out_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && advance && in_mode_reg && lim_lo <= lim_hi) |=>
            (m_control_out >= $past(lim_lo) && m_control_out <= $past(lim_hi)))
        else $error("control output outside limits");

    a_integ_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && advance && in_mode_reg && lim_lo <= lim_hi) |=>
            (integral_sum_reg >= $past(lim_lo) && integral_sum_reg <= $past(lim_hi)))
        else $error("integral outside limits");

    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg))
        else $error("input stalled with free slot");

    a_mode_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && advance) |=> (auto_active_reg == $past(in_mode_reg)))
        else $error("auto flag does not follow beat mode");

endmodule

`default_nettype wire
